>>> design/stk_pkg.sv
// Shared types and codes for the sorting stack.
// No dependencies; imported by every module of the block.
package stk_pkg;

    typedef logic signed [31:0] word_t;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;
    localparam logic [1:0] KIND_SORT = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OVER  = 2'd1;
    localparam logic [1:0] STATUS_UNDER = 2'd2;

    localparam word_t WORD_UNDERFLOW = -32'sd1;

    localparam int OUT_TDATA_W = 48;

    typedef struct packed {
        logic push;
        logic pop;
        logic sort;
        logic phase;
    } cell_ctrl_t;

endpackage

>>> design/stk_cell.sv
// One stack cell: holds one entry, shifts on push/pop, does compare-exchange on sort.
// Depends on stk_pkg.
module stk_cell #(
    parameter bit IDX_ODD = 1'b0
) (
    input  logic                clk,
    input  stk_pkg::cell_ctrl_t ctrl,
    input  stk_pkg::word_t      above_value,
    input  logic                above_live,
    input  stk_pkg::word_t      below_value,
    input  logic                below_live,
    input  logic                self_live,
    output stk_pkg::word_t      value
);
    import stk_pkg::*;

    word_t value_reg;
    word_t value_next;
    logic  pair_below;

    assign pair_below = (ctrl.phase == IDX_ODD);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.push)
        begin
            value_next = above_value;
        end
        else if (ctrl.pop)
        begin
            value_next = below_value;
        end
        else if (ctrl.sort)
        begin
            if (pair_below)
            begin
                if (self_live && below_live && (value_reg < below_value))
                begin
                    value_next = below_value;
                end
            end
            else
            begin
                if (self_live && above_live && (above_value < value_reg))
                begin
                    value_next = above_value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> design/stack_with_sort.sv
// Bounded LIFO stack of signed words built as a chain of cells, top at cell 0.
// Push, pop and peek: one beat per cycle unless output stalls; result in the cycle
// after acceptance. Sort: odd-even transposition over the held entries, one pass per
// cycle; takes occupancy passes, result after the last (on acceptance if under two).
// Input is stalled during the sort passes. Reset (rst_n low) empties the stack.
// Depends on stk_pkg and stk_cell.
module stack_with_sort #(
    parameter int DEPTH = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // push_value
    input  logic [1:0]                     s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stk_pkg::OUT_TDATA_W-1:0] m_tdata  // read_value, status, is_empty,
                                                     // occupancy, zero pad
);
    import stk_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_SORT = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    cell_ctrl_t       ctrl;
    word_t            cell_value [DEPTH];
    logic [DEPTH-1:0] live;
    logic             accept;
    logic             full;
    logic             empty;
    logic [1:0]       kind;
    word_t            push_value;
    word_t            res_value;
    logic [1:0]       res_status;
    logic             res_load;

    assign kind       = s_tuser;
    assign push_value = s_tdata;
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign s_tready   = (state_reg == STATE_IDLE) && (!out_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;

    always_comb
    begin
        ctrl       = '0;
        ctrl.phase = pass_reg[0];
        ctrl.push  = accept && (kind == KIND_PUSH) && !full;
        ctrl.pop   = accept && (kind == KIND_POP) && !empty;
        ctrl.sort  = (state_reg == STATE_SORT);
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            word_t above_v;
            word_t below_v;
            logic  above_l;
            logic  below_l;

            assign live[k] = (CNT_W'(k) < count_reg);

            if (k == 0)
            begin : g_top
                assign above_v = push_value;
                assign above_l = 1'b0;
            end
            else
            begin : g_mid_a
                assign above_v = cell_value[k-1];
                assign above_l = live[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_bot
                assign below_v = '0;
                assign below_l = 1'b0;
            end
            else
            begin : g_mid_b
                assign below_v = cell_value[k+1];
                assign below_l = live[k+1];
            end

            stk_cell #(
                .IDX_ODD (1'(k % 2))
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .above_value (above_v),
                .above_live  (above_l),
                .below_value (below_v),
                .below_live  (below_l),
                .self_live   (live[k]),
                .value       (cell_value[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pass_next  = pass_reg;
        res_value  = '0;
        res_status = STATUS_OK;
        res_load   = 1'b0;
        case (state_reg)
            STATE_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_PUSH:
                        begin
                            res_load = 1'b1;
                            if (full)
                            begin
                                res_status = STATUS_OVER;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            res_load = 1'b1;
                            if (empty)
                            begin
                                res_status = STATUS_UNDER;
                                res_value  = WORD_UNDERFLOW;
                            end
                            else
                            begin
                                res_value = cell_value[0];
                                if (kind == KIND_POP)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                state_next = STATE_SORT;
                                pass_next  = count_reg;
                            end
                        end
                    endcase
                end
            end
            STATE_SORT:
            begin
                pass_next = pass_reg - CNT_W'(1);
                if (pass_reg == CNT_W'(1))
                begin
                    res_load   = 1'b1;
                    state_next = STATE_IDLE;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'b0, 8'(count_next), (count_next == '0), res_status, res_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            count_reg     <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> design/stk_checker.sv
// Port-level checks for the sorting stack, bound to the top level.
// Depends on stk_pkg and stack_with_sort.
module stk_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [stk_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import stk_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result is stalled");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34] |-> (m_tdata[42:35] == 8'd0))
        else $error("empty flag with nonzero occupancy");

    a_under: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == STATUS_UNDER) |->
            (m_tdata[31:0] == 32'hFFFF_FFFF) && m_tdata[34])
        else $error("underflow beat malformed");

    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == STATUS_OVER) |->
            (m_tdata[31:0] == 32'd0) && !m_tdata[34])
        else $error("overflow beat malformed");

endmodule

bind stack_with_sort stk_checker u_stk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
